[sv/texture_streak_smear_top_defines.svh]
// Assertion macros for the streak smear block
`ifndef TEXTURE_STREAK_SMEAR_TOP_DEFINES_SVH
`define TEXTURE_STREAK_SMEAR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TSS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TSS_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSS_ASSERT(label, clk, rst_n, prop, msg)
`define TSS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[sv/tss_pkg.sv]
// ----------------------------------------------------------------------------
// tss_pkg
// Types and constants shared by the streak smear block.
// ----------------------------------------------------------------------------
package tss_pkg;
  localparam int unsigned DefMaxWidth  = 256;
  localparam int unsigned DefMaxHeight = 256;
  localparam int unsigned DefHalfSpan  = 2;
  localparam logic [15:0] QOne         = 16'd32768;
  localparam logic [15:0] FalloffReset = 16'd328;
  localparam logic [8:0]  SizeReset    = 9'd256;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_READ   = 2'd1,
    KIND_STREAK = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_FALLOFF = 2'd0,
    CFG_WIDTH   = 2'd1,
    CFG_HEIGHT  = 2'd2,
    CFG_UNUSED  = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD_WAIT, ST_RD_DONE, ST_CTR_RD, ST_CTR_WAIT,
    ST_PX_RD, ST_PX_WAIT, ST_PX_WR, ST_ROW_END, ST_DONE
  } state_e;

  // memory port request from the sequencer
  typedef struct packed {
    logic        rd;
    logic        wr;
    logic [15:0] wdata;
  } mem_req_t;
endpackage

[sv/tss_store.sv]
// ----------------------------------------------------------------------------
// tss_store
// Single-port texture memory with registered read data.
// ----------------------------------------------------------------------------
module tss_store #(
  parameter int unsigned AddrW = 16
) (
  input  logic               clk_i,
  input  tss_pkg::mem_req_t  req_i,
  input  logic [AddrW-1:0]   addr_i,
  output logic [15:0]        rdata_o
);
  import tss_pkg::*;

  logic [15:0] mem_q [2**AddrW];

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem_q[addr_i] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_o <= mem_q[addr_i];
    end
  end
endmodule

[sv/tss_seq.sv]
// ----------------------------------------------------------------------------
// tss_seq
// Sequencer: clearing sweep, pixel access and streak read-modify-write walk.
// ----------------------------------------------------------------------------
module tss_seq #(
  parameter int unsigned MaxWidth  = 256,
  parameter int unsigned MaxHeight = 256,
  parameter int unsigned HalfSpan  = 2,
  localparam int unsigned XW = $clog2(MaxWidth),
  localparam int unsigned YW = $clog2(MaxHeight),
  localparam int unsigned AW = XW + YW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         kind_i,
  input  logic [7:0]         col_i,
  input  logic [7:0]         row_i,
  input  logic [15:0]        pixel_in_i,
  input  logic [15:0]        falloff_i,
  input  logic [8:0]         width_i,
  input  logic [8:0]         height_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [15:0]        pixel_out_o,
  output logic [8:0]         rows_touched_o,
  output tss_pkg::mem_req_t  req_o,
  output logic [AW-1:0]      addr_o,
  input  logic [15:0]        rdata_i
);
  import tss_pkg::*;

  localparam int unsigned CW = (XW > 8 ? XW : 8) + 2;
  localparam int unsigned SW = $clog2(2*HalfSpan+1) + 1;

  state_e state_q, state_d;
  logic [AW:0]    clr_q, clr_d;
  logic [XW-1:0]  x_q, x_d;
  logic [YW-1:0]  y_q, y_d;
  logic [SW-1:0]  j_q, j_d;
  logic [16:0]    str_q, str_d;
  logic [15:0]    ctr_q, ctr_d;
  logic [8:0]     rows_q, rows_d;
  logic [15:0]    pix_q, pix_d;
  logic [XW:0]    cx_q, cx_d;

  logic [12:0] w_act, h_act;
  logic [12:0] xc, yc;
  logic signed [CW:0] cx_s;
  logic [16:0] sum;
  logic signed [18:0] ns;

  always_comb begin
    w_act = (width_i == '0) ? 13'd1 :
            ({4'd0, width_i} > 13'(MaxWidth)) ? 13'(MaxWidth) : {4'd0, width_i};
    h_act = (height_i == '0) ? 13'd1 :
            ({4'd0, height_i} > 13'(MaxHeight)) ? 13'(MaxHeight) : {4'd0, height_i};
    xc = ({5'd0, col_i} >= w_act) ? w_act - 13'd1 : {5'd0, col_i};
    yc = ({5'd0, row_i} >= h_act) ? h_act - 13'd1 : {5'd0, row_i};
    cx_s = $signed({1'b0, CW'(x_q)}) + $signed({1'b0, CW'(j_q)})
         - $signed((CW+1)'(HalfSpan));
    sum  = {1'b0, rdata_i} + str_q;
    ns   = $signed({2'b0, str_q}) + $signed({3'b0, ctr_q}) - $signed({3'b0, falloff_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; j_q <= j_d; str_q <= str_d;
    ctr_q <= ctr_d; rows_q <= rows_d; pix_q <= pix_d; cx_q <= cx_d;
  end

  always_comb begin
    state_d = state_q; clr_d = clr_q;
    x_d = x_q; y_d = y_q; j_d = j_q; str_d = str_q; ctr_d = ctr_q;
    rows_d = rows_q; pix_d = pix_q; cx_d = cx_q;
    req_o = '0;
    addr_o = {y_q, x_q};
    busy_o = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        req_o.wr = 1'b1;
        addr_o = clr_q[AW-1:0];
        clr_d = clr_q + 1'b1;
        if (clr_q[AW-1:0] == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          x_d = xc[XW-1:0]; y_d = yc[YW-1:0];
          rows_d = '0; pix_d = '0;
          str_d = {1'b0, QOne};
          unique case (kind_e'(kind_i))
            KIND_WRITE: begin
              pix_d = (pixel_in_i > QOne) ? QOne : pixel_in_i;
              req_o.wr = 1'b1;
              req_o.wdata = pix_d;
              addr_o = {yc[YW-1:0], xc[XW-1:0]};
              state_d = ST_DONE;
            end
            KIND_READ:   state_d = ST_RD_WAIT;
            KIND_STREAK: state_d = ST_CTR_RD;
            default:     state_d = ST_DONE;
          endcase
          if (kind_e'(kind_i) == KIND_READ) begin
            req_o.rd = 1'b1;
            addr_o = {yc[YW-1:0], xc[XW-1:0]};
          end
        end
      end
      ST_RD_WAIT: state_d = ST_RD_DONE;
      ST_RD_DONE: begin
        pix_d = rdata_i;
        state_d = ST_DONE;
      end
      ST_CTR_RD: begin
        req_o.rd = 1'b1;
        state_d = ST_CTR_WAIT;
      end
      ST_CTR_WAIT: begin
        j_d = '0;
        state_d = ST_PX_RD;
      end
      ST_PX_RD: begin
        if (j_q == SW'(0)) ctr_d = rdata_i;
        if (cx_s >= 0 && cx_s < $signed({1'b0, CW'(w_act)})) begin
          cx_d = cx_s[XW:0];
          req_o.rd = 1'b1;
          addr_o = {y_q, cx_s[XW-1:0]};
          state_d = ST_PX_WAIT;
        end else if (j_q == SW'(2*HalfSpan)) begin
          state_d = ST_ROW_END;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_PX_WAIT: state_d = ST_PX_WR;
      ST_PX_WR: begin
        req_o.wr = 1'b1;
        addr_o = {y_q, cx_q[XW-1:0]};
        req_o.wdata = (sum > {1'b0, QOne}) ? QOne : sum[15:0];
        if (j_q == SW'(2*HalfSpan)) state_d = ST_ROW_END;
        else begin
          j_d = j_q + 1'b1;
          state_d = ST_PX_RD;
        end
      end
      ST_ROW_END: begin
        rows_d = rows_q + 1'b1;
        str_d = (ns < 0) ? 17'd0 : (ns > $signed({3'b0, QOne})) ? {1'b0, QOne} : ns[16:0];
        if (y_q == '0 || str_d == '0) state_d = ST_DONE;
        else begin
          y_d = y_q - 1'b1;
          state_d = ST_CTR_RD;
        end
      end
      ST_DONE: begin
        done_o = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign pixel_out_o = pix_q;
  assign rows_touched_o = rows_q;
endmodule

[sv/texture_streak_smear_top.sv]
// ----------------------------------------------------------------------------
// texture_streak_smear_top
// Texture store with pixel write, pixel read and upward streak smear.
// ----------------------------------------------------------------------------
// Usage: raise start_i with kind_i, col_i, row_i, pixel_in_i while busy_o is
// low; the word is taken at that edge. One result word follows on
// pixel_out_o/rows_touched_o, marked by done_o for one cycle; the receiver
// cannot stall it. Configuration words go over cfg_valid_i/cfg_ready_o with
// cfg_index_i and cfg_data_i and should be written while the block is idle.
// A write or an invalid kind goes from idle straight to the result; a read
// waits on the registered memory data. A streak reads the centre texel of a
// row, then reads and writes back each in-range pixel of the span, skipping
// those outside the width, and moves up a row; up to 256 rows.
// Reset: the state and configuration registers take their reset values and
// the memory is cleared by a sweep over every address, with busy_o high;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`include "texture_streak_smear_top_defines.svh"
module texture_streak_smear_top #(
  parameter int unsigned MaxWidth  = tss_pkg::DefMaxWidth,
  parameter int unsigned MaxHeight = tss_pkg::DefMaxHeight,
  parameter int unsigned HalfSpan  = tss_pkg::DefHalfSpan
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  col_i,
  input  logic [7:0]  row_i,
  input  logic [15:0] pixel_in_i,
  output logic        done_o,
  output logic [15:0] pixel_out_o,
  output logic [8:0]  rows_touched_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import tss_pkg::*;

  localparam int unsigned AW = $clog2(MaxWidth) + $clog2(MaxHeight);

  logic [15:0] falloff_q;
  logic [8:0]  width_q, height_q;
  mem_req_t    req;
  logic [AW-1:0] addr;
  logic [15:0] rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      falloff_q <= FalloffReset;
      width_q   <= SizeReset;
      height_q  <= SizeReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FALLOFF: falloff_q <= cfg_data_i;
        CFG_WIDTH:   width_q   <= cfg_data_i[8:0];
        CFG_HEIGHT:  height_q  <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  tss_seq #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight), .HalfSpan(HalfSpan)) u_seq (
    .clk_i, .rst_ni, .start_i, .kind_i, .col_i, .row_i, .pixel_in_i,
    .falloff_i(falloff_q), .width_i(width_q), .height_i(height_q),
    .busy_o, .done_o, .pixel_out_o, .rows_touched_o,
    .req_o(req), .addr_o(addr), .rdata_i(rdata)
  );

  tss_store #(.AddrW(AW)) u_store (
    .clk_i, .req_i(req), .addr_i(addr), .rdata_o(rdata)
  );

  `TSS_ASSERT(a_done_busy, clk_i, rst_ni, done_o |-> busy_o, "result while idle")
  `TSS_ASSERT(a_done_pulse, clk_i, rst_ni, done_o |=> !done_o, "result longer than a cycle")
  `TSS_ASSERT(a_no_rw, clk_i, rst_ni, !(req.rd && req.wr), "read and write together")
  `TSS_ASSERT(a_done_idle, clk_i, rst_ni, done_o |=> !busy_o, "no return to idle")
endmodule

[tb/sv/tb_texture_streak_smear_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_texture_streak_smear_top
// Self-checking bench for the streak smear block: pixel writes, reads, streaks
// and invalid words are driven with random gaps, results are predicted from a
// local copy of the texture and compared word by word, over several register
// settings including the extremes.
// ----------------------------------------------------------------------------
module tb_texture_streak_smear_top;
  import tss_pkg::*;

  localparam int unsigned TexW = 256;
  localparam int unsigned TexH = 256;
  localparam int unsigned Span = 2;
  localparam int Unity = 32768;

  typedef struct {
    logic [15:0] pixel;
    logic [8:0]  rows;
  } smear_res_t;

  class smear_scoreboard;
    logic [15:0] texel[TexW*TexH];
    int unsigned falloff_q, width_q, height_q;
    smear_res_t  awaited[$];
    int unsigned errors, words_in, words_out, streaks, streak_rows;

    function new();
      foreach (texel[i]) texel[i] = '0;
      falloff_q = FalloffReset;
      width_q   = SizeReset;
      height_q  = SizeReset;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] data);
      case (idx)
        CFG_FALLOFF: falloff_q = data;
        CFG_WIDTH:   width_q   = data[8:0];
        CFG_HEIGHT:  height_q  = data[8:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_size(int unsigned v, int unsigned lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
    endfunction

    function void note_word(kind_e kind, logic [7:0] col, logic [7:0] row,
                            logic [15:0] pin);
      int unsigned w, h, x, y, a, v;
      int strength, centre, cx;
      smear_res_t res;
      w = eff_size(width_q, TexW);
      h = eff_size(height_q, TexH);
      x = (col >= w) ? w - 1 : col;
      y = (row >= h) ? h - 1 : row;
      res.pixel = '0;
      res.rows  = '0;
      case (kind)
        KIND_WRITE: begin
          v = (pin > Unity) ? Unity : pin;
          texel[y*TexW + x] = v[15:0];
          res.pixel = v[15:0];
        end
        KIND_READ: res.pixel = texel[y*TexW + x];
        KIND_STREAK: begin
          strength = Unity;
          streaks++;
          while (strength > 0) begin
            centre = texel[y*TexW + x];
            for (int j = -int'(Span); j <= int'(Span); j++) begin
              cx = int'(x) + j;
              if (cx >= 0 && cx < int'(w)) begin
                a = y*TexW + cx;
                v = texel[a] + strength;
                if (v > Unity) v = Unity;
                texel[a] = v[15:0];
              end
            end
            res.rows++;
            strength = strength + centre - int'(falloff_q);
            if (strength < 0) strength = 0;
            if (strength > Unity) strength = Unity;
            if (y == 0) break;
            y--;
          end
          streak_rows += res.rows;
        end
        default: ;
      endcase
      words_in++;
      awaited.push_back(res);
    endfunction

    function void check_word(logic [15:0] pix, logic [8:0] rows);
      smear_res_t exp_r;
      words_out++;
      if (awaited.size() == 0) begin
        $error("result word with nothing awaited: pixel_out %0d rows_touched %0d",
               pix, rows);
        errors++;
        return;
      end
      exp_r = awaited.pop_front();
      if (pix !== exp_r.pixel) begin
        $error("pixel_out: expected %0d, got %0d", exp_r.pixel, pix);
        errors++;
      end
      if (rows !== exp_r.rows) begin
        $error("rows_touched: expected %0d, got %0d", exp_r.rows, rows);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic        clk, rst_n;
  logic        start, busy, done, cfg_valid, cfg_ready;
  kind_e       kind;
  logic [7:0]  col, row;
  logic [15:0] pixel_in, pixel_out, cfg_data;
  logic [8:0]  rows_touched;
  cfg_idx_e    cfg_index;
  bit          calm;  // no gaps while set
  smear_scoreboard sb;

  texture_streak_smear_top u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_o        (busy),
    .kind_i        (kind),
    .col_i         (col),
    .row_i         (row),
    .pixel_in_i    (pixel_in),
    .done_o        (done),
    .pixel_out_o   (pixel_out),
    .rows_touched_o(rows_touched),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && done) sb.check_word(pixel_out, rows_touched);
  end

  task automatic write_reg(cfg_idx_e idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_word(kind_e k, logic [7:0] c, logic [7:0] r, logic [15:0] p);
    start    <= 1'b1;
    kind     <= k;
    col      <= c;
    row      <= r;
    pixel_in <= p;
    do @(posedge clk); while (busy);
    sb.note_word(k, c, r, p);
    if (!calm && $urandom_range(99) < 36) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // let every awaited word arrive, then a short settle before touching registers
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_word(int unsigned w, int unsigned h);
    int unsigned pick;
    logic [7:0] c, r;
    logic [15:0] p;
    pick = $urandom_range(99);
    c = (pick % 4 == 0) ? 8'($urandom) : 8'($urandom_range(w - 1));
    r = 8'($urandom_range(h - 1));
    p = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(Unity));
    if (pick < 40) send_word(KIND_WRITE, c, 8'($urandom), p);
    else if (pick < 68) send_word(KIND_READ, c, 8'($urandom), p);
    else if (pick < 95) begin
      // streaks mostly in rows 0 to 15 to keep walks short
      if ($urandom_range(19) != 0) r = 8'($urandom_range(15));
      send_word(KIND_STREAK, c, r, 16'($urandom));
    end else send_word(KIND_NONE, 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  initial begin
    logic [15:0] fo;
    logic [8:0]  wv, hv;
    sb        = new();
    rst_n     = 1'b0;
    start     = 1'b0;
    kind      = KIND_NONE;
    col       = '0;
    row       = '0;
    pixel_in  = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FALLOFF;
    cfg_data  = '0;
    calm      = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every kind, clamping and saturation
    send_word(KIND_WRITE, 8'd0, 8'd0, 16'd32768);
    send_word(KIND_READ, 8'd0, 8'd0, 16'hFFFF);
    send_word(KIND_WRITE, 8'd255, 8'd255, 16'hFFFF);
    send_word(KIND_READ, 8'd255, 8'd255, 16'd0);
    send_word(KIND_WRITE, 8'd1, 8'd200, 16'd32769);
    send_word(KIND_WRITE, 8'd2, 8'd3, 16'd0);
    send_word(KIND_NONE, 8'hFF, 8'hFF, 16'hFFFF);
    send_word(KIND_STREAK, 8'd0, 8'd0, 16'd0);
    send_word(KIND_STREAK, 8'd255, 8'd20, 16'd0);
    send_word(KIND_STREAK, 8'd128, 8'd255, 16'd0);
    send_word(KIND_READ, 8'd129, 8'd100, 16'd0);
    drain();
    write_reg(CFG_WIDTH, 16'd0);
    write_reg(CFG_HEIGHT, 16'h01FF);
    write_reg(CFG_FALLOFF, 16'hFFFF);
    send_word(KIND_WRITE, 8'd77, 8'd9, 16'd12345);
    send_word(KIND_READ, 8'd0, 8'd9, 16'd0);
    send_word(KIND_STREAK, 8'd200, 8'd30, 16'd0);
    drain();
    write_reg(CFG_WIDTH, 16'd5);
    write_reg(CFG_HEIGHT, 16'd0);
    write_reg(CFG_FALLOFF, 16'd0);
    send_word(KIND_WRITE, 8'd255, 8'd255, 16'd700);
    send_word(KIND_STREAK, 8'd255, 8'd255, 16'd0);
    send_word(KIND_READ, 8'd3, 8'd0, 16'd0);
    drain();
    write_reg(CFG_FALLOFF, 16'd32768);
    write_reg(CFG_WIDTH, 16'd256);
    write_reg(CFG_HEIGHT, 16'd12);
    send_word(KIND_STREAK, 8'd1, 8'd11, 16'd0);
    send_word(KIND_READ, 8'd0, 8'd11, 16'd0);
    drain();

    // random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin fo = FalloffReset; wv = 9'd256; hv = 9'd256; end
        1: begin fo = 16'd0; wv = 9'd1; hv = 9'd16; end
        2: begin fo = 16'd32768; wv = 9'd511; hv = 9'd1; end
        default: begin
          fo = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4000));
          wv = 9'($urandom);
          hv = 9'($urandom_range(1, 256));
        end
      endcase
      write_reg(CFG_FALLOFF, fo);
      write_reg(CFG_WIDTH, 16'(wv));
      write_reg(CFG_HEIGHT, 16'(hv));
      calm = (ph == 4);
      for (int n = 0; n < 190; n++) begin
        random_word(sb.eff_size(wv, TexW), sb.eff_size(hv, TexH));
        if (n == 95) drain();
      end
      calm = 1'b0;
      drain();
    end

    repeat (40) @(posedge clk);
    $display("Covered %0d words (%0d streaks over %0d rows) and %0d results",
             sb.words_in, sb.streaks, sb.streak_rows, sb.words_out);
    $display("across six random register settings plus directed extremes.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(64'd30_000_000 * 12);
    $display("Simulation FAILED");
    $finish;
  end
endmodule
